// ===== rtl/core/mcpt_pkg.sv =====
// shared types and codes for the multi-channel pipe table
package mcpt_pkg;

	// request codes
	localparam logic [1:0] REQ_OPEN  = 2'd0;
	localparam logic [1:0] REQ_CLOSE = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NO_PIPE    = 2'd1;
	localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
	localparam logic [1:0] STAT_BUF_LIMIT  = 2'd3;

	// attach count ceiling
	localparam logic [7:0] COUNT_MAX = 8'd255;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDATA
	} mcpt_state_t;

	// decision from the slot table to the sequencer
	typedef struct packed {
		logic [1:0] status;
		logic       freed;
		logic       mem_wr;
		logic       mem_rd;
	} mcpt_ctl_t;

endpackage

// ===== rtl/core/mcpt_if.sv =====
// request and response channel interfaces
interface mcpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] pipe_id;
	logic [7:0]  data_byte;

	modport source (output valid, output req_type, output pipe_id, output data_byte,
		input ready);
	modport sink (input valid, input req_type, input pipe_id, input data_byte,
		output ready);
endinterface

interface mcpt_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] read_byte;
	logic       slot_freed;

	modport source (output valid, output status, output read_byte, output slot_freed,
		input ready);
	modport sink (input valid, input status, input read_byte, input slot_freed,
		output ready);
endinterface

// ===== rtl/core/mcpt_ram.sv =====
// generic single-port ram with registered read
module mcpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/core/mcpt_slot_table.sv =====
// slot table: identifier match, free slot search and per-slot counters
module mcpt_slot_table import mcpt_pkg::*; #(
	parameter int NUM_PIPES    = 8,
	parameter int BUFFER_DEPTH = 256,
	localparam int AW = $clog2(NUM_PIPES * BUFFER_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          strobe,
	input  logic [1:0]    req_type,
	input  logic [15:0]   pipe_id,
	output mcpt_ctl_t     ctl,
	output logic [AW-1:0] mem_addr
);

	localparam int SW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PW = $clog2(BUFFER_DEPTH);
	localparam int FW = $clog2(BUFFER_DEPTH + 1);

	logic [NUM_PIPES-1:0] in_use_q;
	logic [15:0]          id_q   [NUM_PIPES];
	logic [7:0]           cnt_q  [NUM_PIPES];
	logic [PW-1:0]        rp_q   [NUM_PIPES];
	logic [PW-1:0]        wp_q   [NUM_PIPES];
	logic [FW-1:0]        fill_q [NUM_PIPES];

	logic [NUM_PIPES-1:0] hit_vec;
	logic                 hit;
	logic                 free_any;
	logic [SW-1:0]        hit_idx;
	logic [SW-1:0]        free_idx;
	logic [SW-1:0]        sel;
	logic [7:0]           cur_cnt;
	logic [7:0]           dec_cnt;
	logic [PW-1:0]        cur_rp;
	logic [PW-1:0]        cur_wp;
	logic [FW-1:0]        cur_fill;
	logic                 do_alloc;
	logic                 do_inc;
	logic                 do_close;

	// identifier match and lowest free slot
	always_comb begin
		hit_vec  = '0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			hit_vec[i] = in_use_q[i] && (id_q[i] == pipe_id);
			if (hit_vec[i]) begin
				hit_idx = SW'(i);
			end
			if (!in_use_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
		hit = |hit_vec;
	end

	// selected slot fields
	assign sel      = hit ? hit_idx : free_idx;
	assign cur_cnt  = cnt_q[sel];
	assign cur_rp   = rp_q[sel];
	assign cur_wp   = wp_q[sel];
	assign cur_fill = fill_q[sel];
	assign dec_cnt  = (cur_cnt != 8'd0) ? cur_cnt - 8'd1 : 8'd0;

	// request decision
	always_comb begin
		ctl      = '0;
		do_alloc = 1'b0;
		do_inc   = 1'b0;
		do_close = 1'b0;
		ctl.status = STAT_OK;
		case (req_type)
			REQ_OPEN: begin
				if (hit) begin
					do_inc = 1'b1;
				end else if (free_any) begin
					do_alloc = 1'b1;
				end else begin
					ctl.status = STAT_TABLE_FULL;
				end
			end
			REQ_CLOSE: begin
				if (!hit) begin
					ctl.status = STAT_NO_PIPE;
				end else begin
					do_close  = 1'b1;
					ctl.freed = (dec_cnt == 8'd0);
				end
			end
			REQ_WRITE: begin
				if (!hit) begin
					ctl.status = STAT_NO_PIPE;
				end else if (cur_fill == FW'(BUFFER_DEPTH)) begin
					ctl.status = STAT_BUF_LIMIT;
				end else begin
					ctl.mem_wr = 1'b1;
				end
			end
			default: begin
				if (!hit) begin
					ctl.status = STAT_NO_PIPE;
				end else if (cur_fill == '0) begin
					ctl.status = STAT_BUF_LIMIT;
				end else begin
					ctl.mem_rd = 1'b1;
				end
			end
		endcase
	end

	// byte store address: slot base plus pointer
	assign mem_addr = AW'(sel) * AW'(BUFFER_DEPTH) + AW'(ctl.mem_rd ? cur_rp : cur_wp);

	// occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (strobe) begin
			if (do_alloc) begin
				in_use_q[sel] <= 1'b1;
			end else if (do_close && ctl.freed) begin
				in_use_q[sel] <= 1'b0;
			end
		end
	end

	// per-slot payload; a claimed slot loads its identifier and a count of one, with pointers and fill cleared
	always_ff @(posedge clk) begin
		if (strobe) begin
			if (do_alloc) begin
				id_q[sel]   <= pipe_id;
				cnt_q[sel]  <= 8'd1;
				rp_q[sel]   <= '0;
				wp_q[sel]   <= '0;
				fill_q[sel] <= '0;
			end
			if (do_inc && cur_cnt != COUNT_MAX) begin
				cnt_q[sel] <= cur_cnt + 8'd1;
			end
			if (do_close) begin
				cnt_q[sel] <= dec_cnt;
			end
			if (ctl.mem_wr) begin
				wp_q[sel]   <= (cur_wp == PW'(BUFFER_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
				fill_q[sel] <= cur_fill + 1'b1;
			end
			if (ctl.mem_rd) begin
				rp_q[sel]   <= (cur_rp == PW'(BUFFER_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
				fill_q[sel] <= cur_fill - 1'b1;
			end
		end
	end

	a_unique_id: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("two live slots share one identifier");

	a_read_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (ctl.mem_rd || ctl.mem_wr)) |-> hit)
		else $error("byte access without a matching slot");

	a_freed_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && ctl.freed) |=> !in_use_q[$past(sel)])
		else $error("freed slot still marked in use");

endmodule

// ===== rtl/core/multi_channel_pipe_table.sv =====
// top level of the multi-channel pipe table
//
//  channel  dir  payload                          handshake
//  req      in   req_type, pipe_id, data_byte     valid / ready
//  rsp      out  status, read_byte, slot_freed    valid / ready
//
// an item is accepted, then executed; open, close and write finish there, while
// a read goes on to a read-data state that takes the byte ram's registered read.
// one item is in flight at a time; the next is taken while a result still
// waits in the output register, but execution waits until that register is free.
// reset clears the slot occupancy flags and the sequencer; no ram clearing pass.
module multi_channel_pipe_table import mcpt_pkg::*; #(
	parameter int NUM_PIPES    = 8,
	parameter int BUFFER_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	mcpt_req_if.sink   req,
	mcpt_rsp_if.source rsp
);

	localparam int AW = $clog2(NUM_PIPES * BUFFER_DEPTH);

	mcpt_state_t   state_q;
	mcpt_state_t   state_nxt;
	logic [1:0]    req_type_q;
	logic [15:0]   pipe_id_q;
	logic [7:0]    data_byte_q;
	logic          accept;
	logic          out_free;
	logic          exec_go;
	logic          load_out;
	logic          load_rdata;
	mcpt_ctl_t     ctl;
	logic [AW-1:0] mem_addr;
	logic          ram_we;
	logic          ram_re;
	logic [7:0]    ram_rdata;
	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [7:0]    rsp_byte_q;
	logic          rsp_freed_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and controls
	always_comb begin
		state_nxt  = state_q;
		req.ready  = 1'b0;
		exec_go    = 1'b0;
		load_rdata = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					exec_go   = 1'b1;
					state_nxt = ctl.mem_rd ? S_RDATA : S_IDLE;
				end
			end
			S_RDATA: begin
				load_rdata = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign accept   = req.valid && req.ready;
	assign load_out = (exec_go && !ctl.mem_rd) || load_rdata;
	assign ram_we   = exec_go && ctl.mem_wr;
	assign ram_re   = exec_go && ctl.mem_rd;

	// request holding register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q  <= req.req_type;
			pipe_id_q   <= req.pipe_id;
			data_byte_q <= req.data_byte;
		end
	end

	mcpt_slot_table #(
		.NUM_PIPES    (NUM_PIPES),
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.strobe   (exec_go),
		.req_type (req_type_q),
		.pipe_id  (pipe_id_q),
		.ctl      (ctl),
		.mem_addr (mem_addr)
	);

	mcpt_ram #(
		.WIDTH (8),
		.DEPTH (NUM_PIPES * BUFFER_DEPTH)
	) u_bytes (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (mem_addr),
		.wdata (data_byte_q),
		.rdata (ram_rdata)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_rdata) begin
			rsp_status_q <= STAT_OK;
			rsp_byte_q   <= ram_rdata;
			rsp_freed_q  <= 1'b0;
		end else if (load_out) begin
			rsp_status_q <= ctl.status;
			rsp_byte_q   <= 8'd0;
			rsp_freed_q  <= ctl.freed;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.read_byte  = rsp_byte_q;
	assign rsp.slot_freed = rsp_freed_q;

	a_ram_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("byte ram read and write in one cycle");

	a_rdata_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDATA) |-> ($past(state_q) == S_EXEC))
		else $error("read data stage not preceded by execute");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("pending result overwritten");

	a_rdata_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> !rsp_valid_q)
		else $error("output busy when read data returns");

endmodule
